// ----- sv/hpoc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpoc_pkg
// types and constants shared by the picture order count block
// ----------------------------------------------------------------------------
package hpoc_pkg;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  localparam logic [1:0] MODE_LSB   = 2'd0;
  localparam logic [1:0] MODE_CYCLE = 2'd1;
  localparam logic [1:0] MODE_FRAME = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam logic [1:0] ST_FRAME  = 2'd0;
  localparam logic [1:0] ST_TOP    = 2'd1;
  localparam logic [1:0] ST_BOTTOM = 2'd2;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_LSB    = 3'd1;
  localparam logic [2:0] REG_FN     = 3'd2;
  localparam logic [2:0] REG_CYCLE  = 3'd3;
  localparam logic [2:0] REG_NONREF = 3'd4;
  localparam logic [2:0] REG_TBOFF  = 3'd5;

  typedef struct packed {
    logic        op;
    logic [7:0]  entry_index;
    logic [31:0] entry_value;
    logic        idr_flag;
    logic        reference_flag;
    logic [1:0]  structure;
    logic [15:0] lsb_value;
    logic [15:0] frame_number;
    logic [31:0] delta_bottom;
    logic [31:0] delta_first;
    logic [31:0] delta_second;
    logic        reset_op_flag;
  } in_item_t;

  typedef struct packed {
    logic [31:0] top_count;
    logic [31:0] bottom_count;
    logic [31:0] picture_count;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  poc_mode;
    logic [4:0]  log2_max_lsb;
    logic [4:0]  log2_max_frame_number;
    logic [7:0]  cycle_length;
    logic [31:0] non_ref_offset;
    logic [31:0] top_bottom_offset;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic capture;    // register the input item
    logic prep;       // frame offset, abs frame number, mode 0 / 2 result
    logic sum_clear;  // start a table walk
    logic sum_step;   // accumulate one entry
    logic div_start;
    logic div_step;
    logic mul_step;
    logic finish;     // form the mode 1 result
    logic commit;     // update history, load output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_load;
    logic mode1_walk;  // mode 1 with nonzero abs frame number
    logic sum_done;
    logic div_done;
    logic mul_done;
  } sts_t;

endpackage

// ----- sv/hpoc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpoc_ctrl
// sequencer for one picture: prepare, table walks, division, multiply
// ----------------------------------------------------------------------------
module hpoc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  hpoc_pkg::sts_t sts_i,
  output hpoc_pkg::cmd_t cmd_o
);
  import hpoc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_SUM, S_DIV, S_MUL, S_POS, S_FIN, S_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   take;

  // a new item is taken only when the sequencer is idle and the output register is free
  assign in_stall_o  = (state_q != S_IDLE) || out_valid_q;
  assign take        = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.capture = take;
    case (state_q)
      S_PREP: begin
        cmd_o.prep      = 1'b1;
        cmd_o.sum_clear = 1'b1;
      end
      S_SUM: cmd_o.sum_step = !sts_i.sum_done;
      S_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      S_MUL: cmd_o.mul_step = 1'b1;
      S_POS: cmd_o.sum_step = !sts_i.sum_done;
      S_FIN: cmd_o.finish = 1'b1;
      S_OUT: cmd_o.commit = 1'b1;
      default: ;
    endcase
    if (state_q == S_SUM && sts_i.sum_done) begin
      cmd_o.div_start = 1'b1;
    end
    if (state_q == S_MUL && sts_i.mul_done) begin
      cmd_o.sum_clear = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (take) state_q <= S_PREP;
        S_PREP: begin
          if (sts_i.is_load || !sts_i.mode1_walk) state_q <= S_OUT;
          else state_q <= S_SUM;
        end
        S_SUM: if (sts_i.sum_done) state_q <= S_DIV;
        S_DIV: if (sts_i.div_done) state_q <= S_MUL;
        S_MUL: if (sts_i.mul_done) state_q <= S_POS;
        S_POS: if (sts_i.sum_done) state_q <= S_FIN;
        S_FIN: state_q <= S_OUT;
        S_OUT: begin
          state_q     <= S_IDLE;
          out_valid_q <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/hpoc_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpoc_dpath
// offset table, history registers, walk accumulator, divider and multiplier
// ----------------------------------------------------------------------------
module hpoc_dpath #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hpoc_pkg::cfg_t      cfg_i,
  input  hpoc_pkg::in_item_t  in_item_i,
  input  hpoc_pkg::cmd_t      cmd_i,
  output hpoc_pkg::sts_t      sts_o,
  output hpoc_pkg::out_item_t out_item_o
);
  import hpoc_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [31:0] mem_q [TABLE_DEPTH];
  logic [31:0] rd_q;
  logic        rd_ok_q;

  in_item_t  it_q;
  out_item_t res_q;

  logic [31:0] prev_msb_q;
  logic [15:0] prev_lsb_q, prev_fn_q;
  logic [31:0] prev_fo_q, prev_top_q;
  logic        prev_rst_q, prev_bot_q;

  logic [31:0] top_q, bot_q, pic_q;
  logic [31:0] msb_q, fno_q, absm1_q;
  logic        hist_q;
  logic        walked_q;

  // walk: index counter, limit, accumulator
  logic [8:0]  idx_q, lim_q;
  logic        rd_pend_q;
  logic [31:0] acc_q, delta_q;

  // restoring divider
  logic [31:0] quo_q, rem_q;
  logic [5:0]  dcnt_q;
  // shift-add multiplier
  logic [31:0] mq_q, mp_q, mc_q;
  logic [5:0]  mcnt_q;

  logic [31:0] mode1_top, mode1_bot, mode1_pic, e0;
  logic        nowalk1;
  logic        decode;

  logic [4:0]  l2l, l2f;
  logic [31:0] max_lsb, max_fn;
  logic [15:0] lsb_m, fn_m;
  logic        is_field, is_bottom, rst_h;
  assign l2l = (cfg_i.log2_max_lsb < 5'd4) ? 5'd4 :
               (cfg_i.log2_max_lsb > 5'd16) ? 5'd16 : cfg_i.log2_max_lsb;
  assign l2f = (cfg_i.log2_max_frame_number < 5'd4) ? 5'd4 :
               (cfg_i.log2_max_frame_number > 5'd16) ? 5'd16 :
               cfg_i.log2_max_frame_number;
  assign max_lsb   = 32'd1 << l2l;
  assign max_fn    = 32'd1 << l2f;
  assign lsb_m     = it_q.lsb_value & 16'(max_lsb - 32'd1);
  assign fn_m      = it_q.frame_number & 16'(max_fn - 32'd1);
  assign is_bottom = (it_q.structure == ST_BOTTOM);
  assign is_field  = (it_q.structure == ST_TOP) || is_bottom;
  assign rst_h     = it_q.reset_op_flag;
  assign decode    = (it_q.op == OP_DECODE) && (cfg_i.poc_mode != MODE_NONE);

  // mode 0 unwrap
  logic [31:0] pmsb, plsb, msb0, val0, bot0;
  logic [32:0] cur, pl, half;
  always_comb begin
    pmsb = prev_msb_q;
    plsb = {16'd0, prev_lsb_q};
    if (it_q.idr_flag) begin
      pmsb = '0;
      plsb = '0;
    end else if (prev_rst_q) begin
      pmsb = '0;
      plsb = prev_bot_q ? 32'd0 : prev_top_q;
    end
    cur  = {17'd0, lsb_m};
    pl   = {plsb[31], plsb};
    half = {1'b0, max_lsb >> 1};
    if ($signed(cur) < $signed(pl) && $signed(pl - cur) >= $signed(half))
      msb0 = pmsb + max_lsb;
    else if ($signed(cur) > $signed(pl) && $signed(cur - pl) > $signed(half))
      msb0 = pmsb - max_lsb;
    else
      msb0 = pmsb;
    val0 = msb0 + {16'd0, lsb_m};
    bot0 = val0 + it_q.delta_bottom;
  end

  // frame number offset for modes 1 and 2
  logic [31:0] pfn, pfo, fno, absn, abs1, val2;
  always_comb begin
    pfn = prev_rst_q ? 32'd0 : {16'd0, prev_fn_q};
    pfo = prev_rst_q ? 32'd0 : prev_fo_q;
    if (it_q.idr_flag) fno = '0;
    else fno = ({16'd0, fn_m} < pfn) ? pfo + max_fn : pfo;
    absn = (cfg_i.cycle_length != 8'd0) ? fno + {16'd0, fn_m} : 32'd0;
    abs1 = (!it_q.reference_flag && absn != 32'd0) ? absn - 32'd1 : absn;
    val2 = fno + {16'd0, fn_m};
    val2 = it_q.reference_flag ? (val2 << 1) : ((val2 << 1) - 32'd1);
  end

  // counts loaded at prep: mode 0 and mode 2 results, zero for mode 1
  logic [31:0] top_d, bot_d, pic_d;
  logic        hist_d;
  always_comb begin
    top_d  = '0;
    bot_d  = '0;
    pic_d  = '0;
    hist_d = 1'b1;
    if (cfg_i.poc_mode == MODE_LSB) begin
      hist_d = it_q.reference_flag;
      if (!is_field) begin
        top_d = val0;
        bot_d = bot0;
        pic_d = ($signed(bot0) < $signed(val0)) ? bot0 : val0;
      end else if (!is_bottom) begin
        top_d = val0;
        pic_d = val0;
      end else begin
        bot_d = val0;
        pic_d = val0;
      end
    end else if (cfg_i.poc_mode == MODE_FRAME) begin
      if (!it_q.idr_flag) begin
        pic_d = val2;
        if (!is_field) begin
          top_d = val2;
          bot_d = val2;
        end else if (!is_bottom) begin
          top_d = val2;
        end else begin
          bot_d = val2;
        end
      end
    end
  end

  logic [32:0] rtry;
  assign rtry = {rem_q, quo_q[31]} - {25'd0, cfg_i.cycle_length};

  logic [31:0] exp1, t1, b1, bf1, tw, bw, bfw;
  always_comb begin
    exp1 = acc_q + (it_q.reference_flag ? 32'd0 : cfg_i.non_ref_offset);
    t1   = exp1 + it_q.delta_first;
    b1   = t1 + cfg_i.top_bottom_offset + it_q.delta_second;
    bf1  = exp1 + cfg_i.top_bottom_offset + it_q.delta_first;
    tw   = t1 + mp_q;
    bw   = b1 + mp_q;
    bfw  = bf1 + mp_q;
  end

  assign sts_o.is_load    = (it_q.op == OP_LOAD) || (cfg_i.poc_mode == MODE_NONE);
  assign sts_o.mode1_walk = (cfg_i.poc_mode == MODE_CYCLE) && (abs1 != 32'd0);
  assign sts_o.sum_done   = (idx_q >= lim_q) && !rd_pend_q;
  assign sts_o.div_done   = (dcnt_q == 6'd32);
  assign sts_o.mul_done   = (mcnt_q == 6'd32);
  assign out_item_o       = res_q;

  // table port: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture && in_item_i.op == OP_LOAD &&
        {1'b0, in_item_i.entry_index} < 9'(TABLE_DEPTH))
      mem_q[in_item_i.entry_index[IW-1:0]] <= in_item_i.entry_value;
    rd_q    <= mem_q[idx_q[IW-1:0]];
    rd_ok_q <= (idx_q < 9'(TABLE_DEPTH));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) it_q <= in_item_i;
    if (cmd_i.prep) begin
      msb_q   <= msb0;
      fno_q   <= fno;
      absm1_q <= abs1 - 32'd1;
      top_q   <= top_d;
      bot_q   <= bot_d;
      pic_q   <= pic_d;
      hist_q  <= hist_d;
    end else if (cmd_i.finish) begin
      if (!is_field) begin
        top_q <= tw;
        bot_q <= bw;
        pic_q <= ($signed(bw) < $signed(tw)) ? bw : tw;
      end else if (!is_bottom) begin
        top_q <= tw;
        pic_q <= tw;
      end else begin
        bot_q <= bfw;
        pic_q <= bfw;
      end
    end
    // walk over the table, one entry per cycle with a read in flight
    if (cmd_i.sum_clear) begin
      idx_q     <= '0;
      rd_pend_q <= 1'b0;
      acc_q     <= '0;
      lim_q     <= cmd_i.prep ? {1'b0, cfg_i.cycle_length} : 9'(rem_q) + 9'd1;
    end else if (cmd_i.sum_step) begin
      if (idx_q < lim_q) idx_q <= idx_q + 9'd1;
      rd_pend_q <= (idx_q < lim_q);
      if (rd_pend_q) acc_q <= acc_q + (rd_ok_q ? rd_q : 32'd0);
    end
    if (cmd_i.div_start) begin
      delta_q <= acc_q;
      quo_q   <= absm1_q;
      rem_q   <= '0;
      dcnt_q  <= '0;
      mcnt_q  <= '0;
    end else if (cmd_i.div_step && dcnt_q != 6'd32) begin
      if (!rtry[32]) begin
        rem_q <= rtry[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= {rem_q[30:0], quo_q[31]};
        quo_q <= {quo_q[30:0], 1'b0};
      end
      dcnt_q <= dcnt_q + 6'd1;
      if (dcnt_q == 6'd31) begin
        mq_q <= '0;
      end
    end
    if (cmd_i.div_step && dcnt_q == 6'd32) begin
      mc_q <= quo_q;
      mp_q <= '0;
    end
    if (cmd_i.mul_step && mcnt_q != 6'd32) begin
      if (mcnt_q == 6'd0) begin
        mc_q <= quo_q >> 1;
        mp_q <= quo_q[0] ? delta_q : 32'd0;
        mq_q <= delta_q << 1;
      end else begin
        if (mc_q[0]) mp_q <= mp_q + mq_q;
        mc_q <= mc_q >> 1;
        mq_q <= mq_q << 1;
      end
      mcnt_q <= mcnt_q + 6'd1;
    end
    if (cmd_i.commit) begin
      if (decode) res_q <= {mode1_top, mode1_bot, mode1_pic};
      else res_q <= '0;
    end
  end

  // mode 1 without a walk has an expected count of the non-reference offset only
  assign nowalk1 = (cfg_i.poc_mode == MODE_CYCLE) && !walked_q;
  always_comb begin
    e0 = it_q.reference_flag ? 32'd0 : cfg_i.non_ref_offset;
    mode1_top = top_q;
    mode1_bot = bot_q;
    mode1_pic = pic_q;
    if (nowalk1) begin
      mode1_top = '0;
      mode1_bot = '0;
      if (!is_field) begin
        mode1_top = e0 + it_q.delta_first;
        mode1_bot = mode1_top + cfg_i.top_bottom_offset + it_q.delta_second;
        mode1_pic = ($signed(mode1_bot) < $signed(mode1_top)) ? mode1_bot : mode1_top;
      end else if (!is_bottom) begin
        mode1_top = e0 + it_q.delta_first;
        mode1_pic = mode1_top;
      end else begin
        mode1_bot = e0 + cfg_i.top_bottom_offset + it_q.delta_first;
        mode1_pic = mode1_bot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) walked_q <= 1'b0;
    else if (cmd_i.prep) walked_q <= 1'b0;
    else if (cmd_i.finish) walked_q <= 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_msb_q <= '0;
      prev_lsb_q <= '0;
      prev_fn_q  <= '0;
      prev_fo_q  <= '0;
      prev_rst_q <= 1'b0;
      prev_bot_q <= 1'b0;
      prev_top_q <= '0;
    end else if (cmd_i.commit && decode) begin
      prev_fn_q <= fn_m;
      if (cfg_i.poc_mode == MODE_LSB) begin
        if (it_q.reference_flag) begin
          prev_lsb_q <= lsb_m;
          prev_msb_q <= msb_q;
        end
      end else begin
        prev_fo_q <= fno_q;
      end
      if (hist_q) begin
        prev_rst_q <= rst_h;
        prev_bot_q <= is_bottom;
        prev_top_q <= rst_h ? mode1_top - mode1_pic : mode1_top;
      end
    end
  end

endmodule

// ----- sv/h264_picture_order_count_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h264_picture_order_count_top
// picture order count decoder for all three count types
// ----------------------------------------------------------------------------
// in channel: one transfer per item, a table load or one picture header.
// out channel: one transfer per item with top, bottom and picture counts
// (zero for loads and in mode 3). cfg channel: register index and data,
// to be written only while the block is idle; the block itself does not
// enforce it. Ready is always high. A load, a mode 0 / mode 2 picture or
// a mode 1 picture without a walk passes the prepare and output states
// only. Any other mode 1 picture walks the offset table twice through its
// single read port (over cycle_length entries, then over the position in
// the cycle plus one) and runs a 32-step divider and a 32-step multiplier.
// One item is in flight; in_stall_o stays high until the result has been
// transferred out. While out_stall_i is high the result holds.
// Reset clears history and registers; the offset table holds anything
// until it is loaded.
// ----------------------------------------------------------------------------
module h264_picture_order_count_top #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hpoc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hpoc_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import hpoc_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{poc_mode: 2'd0, log2_max_lsb: 5'd4, log2_max_frame_number: 5'd4,
                 cycle_length: 8'd0, non_ref_offset: 32'd0, top_bottom_offset: 32'd0};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MODE:   cfg_q.poc_mode <= cfg_data_i[1:0];
        REG_LSB:    cfg_q.log2_max_lsb <= cfg_data_i[4:0];
        REG_FN:     cfg_q.log2_max_frame_number <= cfg_data_i[4:0];
        REG_CYCLE:  cfg_q.cycle_length <= cfg_data_i[7:0];
        REG_NONREF: cfg_q.non_ref_offset <= cfg_data_i;
        REG_TBOFF:  cfg_q.top_bottom_offset <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hpoc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  hpoc_dpath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dpath (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .in_item_i(in_data_i), .cmd_i(cmd),
    .sts_o(sts), .out_item_o(out_data_o)
  );

endmodule

// ----- sv/hpoc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpoc_checker
// port-level checks on the picture order count block
// ----------------------------------------------------------------------------
module hpoc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input hpoc_pkg::out_item_t out_data_o
);
  // one item in flight: no input transfer while a result waits
  a_no_take_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken with result pending");

  // a transfer in makes the block busy
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o) else $error("not busy after transfer");

  // no result is shown while the block prepares and outputs the item just taken
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !out_valid_o ##1 !out_valid_o)
    else $error("result too early");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");
endmodule

bind h264_picture_order_count_top hpoc_checker u_hpoc_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o
);

// ----- tb/hpoc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpoc_tb_checker
// watches the in, out and cfg channels of the picture order count block,
// works out the counts each item should give and compares every transfer
// on the out channel with the oldest outstanding prediction
// ----------------------------------------------------------------------------
module hpoc_tb_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  hpoc_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  hpoc_pkg::out_item_t out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  results_o
);
  import hpoc_pkg::*;

  cfg_t        regs;
  logic [31:0] offsets [256];
  logic [31:0] h_msb;
  logic [15:0] h_lsb;
  logic [15:0] h_fn;
  logic [31:0] h_fno;
  logic        h_reset;
  logic        h_bottom;
  logic [31:0] h_top;
  out_item_t   counts_q [$];

  function automatic int clamp_log2(logic [4:0] v);
    return (v < 4) ? 4 : ((v > 16) ? 16 : int'(v));
  endfunction

  function automatic out_item_t predict_counts(in_item_t it);
    out_item_t   r;
    logic [31:0] top, bot, pic, max_lsb, max_fn, lsb, fn, pmsb, msb, val;
    logic [31:0] pfn, pfo, fno, absn, ex, dsum, cnt, pos, cl;
    longint      plsb, cur, half;
    logic        is_field, is_bottom, upd;
    r = '0;
    top = '0; bot = '0; pic = '0;
    if (it.op == OP_LOAD) begin
      offsets[it.entry_index] = it.entry_value;
      return r;
    end
    if (regs.poc_mode == MODE_NONE) return r;
    is_field  = (it.structure == ST_TOP) || (it.structure == ST_BOTTOM);
    is_bottom = (it.structure == ST_BOTTOM);
    max_lsb = 32'd1 << clamp_log2(regs.log2_max_lsb);
    max_fn  = 32'd1 << clamp_log2(regs.log2_max_frame_number);
    lsb = {16'd0, it.lsb_value} & (max_lsb - 1);
    fn  = {16'd0, it.frame_number} & (max_fn - 1);
    upd = 1'b1;
    if (regs.poc_mode == MODE_LSB) begin
      pmsb = h_msb;
      plsb = longint'(h_lsb);
      if (it.idr_flag) begin
        pmsb = '0; plsb = 0;
      end else if (h_reset) begin
        pmsb = '0;
        plsb = h_bottom ? 0 : longint'($signed(h_top));
      end
      cur  = longint'(lsb);
      half = longint'(max_lsb >> 1);
      if (cur < plsb && plsb - cur >= half) msb = pmsb + max_lsb;
      else if (cur > plsb && cur - plsb > half) msb = pmsb - max_lsb;
      else msb = pmsb;
      val = msb + lsb;
      if (!is_field) begin
        top = val;
        bot = val + it.delta_bottom;
        pic = ($signed(bot) < $signed(top)) ? bot : top;
      end else if (!is_bottom) begin
        top = val; pic = val;
      end else begin
        bot = val; pic = val;
      end
      h_fn = fn[15:0];
      if (it.reference_flag) begin
        h_lsb = lsb[15:0];
        h_msb = msb;
      end
      upd = it.reference_flag;
    end else begin
      pfn = {16'd0, h_fn};
      pfo = h_fno;
      if (h_reset) begin
        pfn = '0; pfo = '0;
      end
      if (it.idr_flag) fno = '0;
      else fno = (fn < pfn) ? pfo + max_fn : pfo;
      if (regs.poc_mode == MODE_CYCLE) begin
        cl   = {24'd0, regs.cycle_length};
        absn = (cl != 0) ? fno + fn : '0;
        ex   = '0;
        if (!it.reference_flag && absn != 0) absn = absn - 1;
        if (absn != 0) begin
          dsum = '0;
          for (int i = 0; i < cl; i++) dsum = dsum + offsets[i];
          cnt = (absn - 1) / cl;
          pos = (absn - 1) % cl;
          ex  = cnt * dsum;
          for (int i = 0; i <= pos; i++) ex = ex + offsets[i];
        end
        if (!it.reference_flag) ex = ex + regs.non_ref_offset;
        if (!is_field) begin
          top = ex + it.delta_first;
          bot = top + regs.top_bottom_offset + it.delta_second;
          pic = ($signed(bot) < $signed(top)) ? bot : top;
        end else if (!is_bottom) begin
          top = ex + it.delta_first; pic = top;
        end else begin
          bot = ex + regs.top_bottom_offset + it.delta_first; pic = bot;
        end
      end else if (!it.idr_flag) begin
        absn = fno + fn;
        val  = it.reference_flag ? 2 * absn : 2 * absn - 1;
        pic  = val;
        if (!is_field) begin
          top = val; bot = val;
        end else if (!is_bottom) top = val;
        else bot = val;
      end
      h_fn  = fn[15:0];
      h_fno = fno;
    end
    if (upd) begin
      h_reset  = it.reset_op_flag;
      h_bottom = is_bottom;
      h_top    = it.reset_op_flag ? top - pic : top;
    end
    r.top_count     = top;
    r.bottom_count  = bot;
    r.picture_count = pic;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      regs = '{poc_mode: MODE_LSB, log2_max_lsb: 5'd4, log2_max_frame_number: 5'd4,
               cycle_length: 8'd0, non_ref_offset: '0, top_bottom_offset: '0};
      h_msb = '0; h_lsb = '0; h_fn = '0; h_fno = '0;
      h_reset = 1'b0; h_bottom = 1'b0; h_top = '0;
      counts_q.delete();
      errors_o  = 0;
      pending_o = 0;
      results_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MODE:   regs.poc_mode = cfg_data_i[1:0];
          REG_LSB:    regs.log2_max_lsb = cfg_data_i[4:0];
          REG_FN:     regs.log2_max_frame_number = cfg_data_i[4:0];
          REG_CYCLE:  regs.cycle_length = cfg_data_i[7:0];
          REG_NONREF: regs.non_ref_offset = cfg_data_i;
          REG_TBOFF:  regs.top_bottom_offset = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (counts_q.size() == 0) begin
          $error("unexpected result transfer %h", out_data_i);
          errors_o++;
        end else begin
          want = counts_q.pop_front();
          if (out_data_i.top_count !== want.top_count) begin
            $error("top_count: expected %h, got %h", want.top_count, out_data_i.top_count);
            errors_o++;
          end
          if (out_data_i.bottom_count !== want.bottom_count) begin
            $error("bottom_count: expected %h, got %h",
                   want.bottom_count, out_data_i.bottom_count);
            errors_o++;
          end
          if (out_data_i.picture_count !== want.picture_count) begin
            $error("picture_count: expected %h, got %h",
                   want.picture_count, out_data_i.picture_count);
            errors_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) counts_q.push_back(predict_counts(in_data_i));
      pending_o = counts_q.size();
    end
  end

endmodule

// ----- tb/tb_h264_picture_order_count_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_h264_picture_order_count_top
// drives table loads and picture headers through the picture order count
// block over a series of register settings in all count types, with random
// idling on both sides; hpoc_tb_checker predicts and compares the counts
// ----------------------------------------------------------------------------
module tb_h264_picture_order_count_top;
  import hpoc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  int          errors;
  int          pending;
  int          results;

  int          send_pct;
  int          recv_pct;
  bit          hold_req;
  int          hold_left;
  bit          written [256];
  int          n_items;
  logic [15:0] s_lsb;
  logic [15:0] s_fn;

  h264_picture_order_count_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  hpoc_tb_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #48_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("tb_h264_picture_order_count_top: errors");
    $finish;
  end

  // receiver: random stalls, or one long hold-off counted here
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_pct);
      end
    end
  end

  task automatic send_item(in_item_t it);
    bit ok;
    if ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    if (it.op == OP_LOAD) written[it.entry_index] = 1'b1;
    n_items++;
    forever begin
      @(negedge clk);
      ok = !in_stall;
      @(posedge clk);
      if (ok) break;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    bit ok;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
      if (ok) break;
    end
  endtask

  task automatic set_regs(logic [1:0] mode, logic [4:0] l_lsb, logic [4:0] l_fn,
                          logic [7:0] cl, logic [31:0] nonref, logic [31:0] tboff);
    drain();
    repeat (4) @(posedge clk);
    write_reg(REG_MODE, {30'd0, mode});
    write_reg(REG_LSB, {27'd0, l_lsb});
    write_reg(REG_FN, {27'd0, l_fn});
    write_reg(REG_CYCLE, {24'd0, cl});
    write_reg(REG_NONREF, nonref);
    write_reg(REG_TBOFF, tboff);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_item_t load_item(logic [7:0] idx, logic [31:0] val);
    in_item_t it;
    it = '0;
    it.op = OP_LOAD;
    it.entry_index = idx;
    it.entry_value = val;
    return it;
  endfunction

  function automatic in_item_t pic_item(logic idr, logic ref_f, logic [1:0] st,
                                        logic [15:0] lsb, logic [15:0] fn,
                                        logic [31:0] d0, logic rst_f);
    in_item_t it;
    it = '0;
    it.op = OP_DECODE;
    it.idr_flag = idr;
    it.reference_flag = ref_f;
    it.structure = st;
    it.lsb_value = lsb;
    it.frame_number = fn;
    it.delta_bottom = d0;
    it.delta_first = d0;
    it.delta_second = ~d0;
    it.reset_op_flag = rst_f;
    return it;
  endfunction

  // mostly a plausible stream of headers, some noise, a few table loads
  function automatic in_item_t next_header();
    in_item_t     it;
    int           pick;
    logic [191:0] raw;
    pick = $urandom_range(99);
    if (pick < 8) return load_item(8'($urandom_range(255)), $urandom);
    if (pick < 20) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      it = raw[$bits(in_item_t)-1:0];
      it.op = OP_DECODE;
      return it;
    end
    it = '0;
    it.op = OP_DECODE;
    it.idr_flag = ($urandom_range(99) < 5);
    it.reference_flag = ($urandom_range(99) < 70);
    it.structure = ($urandom_range(99) < 4) ? 2'd3 : 2'($urandom_range(2));
    it.reset_op_flag = ($urandom_range(99) < 6);
    if (it.idr_flag) begin
      s_lsb = '0; s_fn = '0;
    end else begin
      s_lsb = s_lsb + 16'($urandom_range(8));
      if (it.reference_flag) s_fn = s_fn + 16'd1;
    end
    it.lsb_value = s_lsb;
    it.frame_number = s_fn;
    if ($urandom_range(9) == 0) begin
      it.delta_bottom = $urandom; it.delta_first = $urandom; it.delta_second = $urandom;
    end else begin
      it.delta_bottom = 32'($signed($urandom_range(8)) - 4);
      it.delta_first  = 32'($signed($urandom_range(8)) - 4);
      it.delta_second = 32'($signed($urandom_range(8)) - 4);
    end
    return it;
  endfunction

  // entries 0 .. cl-1 must hold something before a mode 1 walk reads them
  task automatic fill_table(int cl);
    for (int i = 0; i < cl; i++)
      if (!written[i]) send_item(load_item(8'(i), $urandom));
  endtask

  task automatic run_phase(int count, int hold_at, int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      if (i == pause_at) drain();
      send_item(next_header());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_MODE;
    cfg_data = '0;
    hold_req = 1'b0;
    send_pct = 15;
    recv_pct = 54;
    n_items = 0;
    s_lsb = '0;
    s_fn = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: table extremes, then mode 0 corner pictures at reset settings
    send_item(load_item(8'd0, 32'h7fff_ffff));
    send_item(load_item(8'd1, 32'h8000_0000));
    send_item(load_item(8'd2, 32'hffff_ffff));
    send_item(load_item(8'd3, 32'h0000_0000));
    send_item(load_item(8'd255, 32'h5555_aaaa));
    send_item(pic_item(1'b1, 1'b1, ST_FRAME, 16'h0000, 16'h0000, 32'h7fff_ffff, 1'b0));
    send_item(pic_item(1'b0, 1'b1, ST_TOP, 16'hffff, 16'hffff, 32'h8000_0000, 1'b0));
    send_item(pic_item(1'b0, 1'b1, ST_BOTTOM, 16'h0007, 16'h0001, 32'hffff_ffff, 1'b0));
    send_item(pic_item(1'b0, 1'b0, 2'd3, 16'h000e, 16'h0002, 32'h0000_0001, 1'b0));
    send_item(pic_item(1'b0, 1'b1, ST_TOP, 16'h0003, 16'h0003, 32'h0, 1'b1));
    send_item(pic_item(1'b0, 1'b1, ST_FRAME, 16'h000c, 16'h0004, 32'h0, 1'b0));
    send_item(pic_item(1'b0, 1'b1, ST_BOTTOM, 16'h0005, 16'h0005, 32'h0, 1'b1));
    send_item(pic_item(1'b0, 1'b1, ST_FRAME, 16'h0009, 16'h0006, 32'h8000_0000, 1'b0));
    send_item(pic_item(1'b0, 1'b1, ST_FRAME, 16'h0001, 16'h0007, 32'h0, 1'b1));
    send_item(pic_item(1'b0, 1'b0, ST_FRAME, 16'h000f, 16'h0008, 32'h7fff_ffff, 1'b0));

    set_regs(MODE_LSB, 5'd16, 5'd16, 8'd0, 32'h0, 32'h0);
    run_phase(150, -1, -1);
    set_regs(MODE_CYCLE, 5'd8, 5'd5, 8'd3, $urandom, $urandom);
    fill_table(3);
    run_phase(150, 60, -1);
    set_regs(MODE_CYCLE, 5'd4, 5'd4, 8'd0, 32'h7fff_ffff, 32'h8000_0000);
    run_phase(60, -1, -1);

    send_pct = 54;
    recv_pct = 15;
    set_regs(MODE_FRAME, 5'd4, 5'd4, 8'd17, $urandom, $urandom);
    run_phase(150, -1, 75);
    set_regs(MODE_FRAME, 5'd0, 5'd16, 8'd0, 32'h0, 32'h0);
    run_phase(100, -1, -1);
    set_regs(MODE_CYCLE, 5'd16, 5'd16, 8'd255, 32'h8000_0000, 32'h7fff_ffff);
    fill_table(255);
    run_phase(20, -1, -1);

    send_pct = 0;
    recv_pct = 0;
    set_regs(MODE_LSB, 5'd31, 5'd0, 8'd1, $urandom, $urandom);
    run_phase(150, 40, -1);
    set_regs(MODE_NONE, 5'd10, 5'd10, 8'd2, 32'h0, 32'h0);
    run_phase(20, -1, -1);
    set_regs(MODE_CYCLE, 5'd4, 5'd4, 8'd1, $urandom, $urandom);
    run_phase(150, -1, -1);

    drain();
    repeat (700) @(posedge clk);
    $display("%0d items sent, %0d results checked", n_items, results);
    $display("covered count types 0-3, frames and fields, resets, table walks up to 255");
    if (errors == 0 && pending == 0) begin
      $display("tb_h264_picture_order_count_top: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending);
      $display("tb_h264_picture_order_count_top: errors");
    end
    $finish;
  end

endmodule
